>>> hdl/rtb_pkg.sv
// Shared types and constants for the repeating timer bank.
package rtb_pkg;
  localparam int NumTimers = 16;
  localparam int SlotW = (NumTimers > 1) ? $clog2(NumTimers) : 1;
  localparam int CntW = $clog2(NumTimers + 1);
  localparam int MaxResults = 16;

  localparam logic [1:0] MODE_REGISTER = 2'd0;
  localparam logic [1:0] MODE_UNREGISTER = 2'd1;
  localparam logic [1:0] MODE_PROCESS = 2'd2;
  localparam logic [1:0] MODE_STOP_ALL = 2'd3;

  localparam logic [2:0] KIND_REGISTERED = 3'd0;
  localparam logic [2:0] KIND_REMOVED = 3'd1;
  localparam logic [2:0] KIND_FIRED = 3'd2;
  localparam logic [2:0] KIND_NOTHING_DUE = 3'd3;
  localparam logic [2:0] KIND_FULL = 3'd4;

  typedef struct packed {
    logic [1:0] mode;
    logic [63:0] now_us;
    logic [63:0] start_after_us;
    logic [63:0] repeat_us;
    logic [31:0] target_id;
  } cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [31:0] timer_id;
    logic [63:0] due_time_us;
    logic last;
  } result_t;
endpackage

>>> hdl/rtb_if.sv
// Valid/ready channel interfaces for commands and results.
interface rtb_cmd_if (input logic clk);
  logic valid;
  logic ready;
  logic [1:0] mode;
  logic [63:0] now_us;
  logic [63:0] start_after_us;
  logic [63:0] repeat_us;
  logic [31:0] target_id;
  modport source (output valid, mode, now_us, start_after_us, repeat_us, target_id,
                  input ready);
  modport sink (input valid, mode, now_us, start_after_us, repeat_us, target_id,
                output ready);
endinterface

interface rtb_res_if (input logic clk);
  logic valid;
  logic ready;
  logic [2:0] kind;
  logic [31:0] timer_id;
  logic [63:0] due_time_us;
  logic last;
  modport source (output valid, kind, timer_id, due_time_us, last, input ready);
  modport sink (input valid, kind, timer_id, due_time_us, last, output ready);
endinterface

>>> hdl/repeating_timer_bank.sv
// Top level of the repeating timer bank.
//  channel | dir | beat contents
//  cmd     | in  | mode, now_us, start_after_us, repeat_us, target_id
//  res     | out | kind, timer_id, due_time_us, last
//  cfg     | in  | reload_from_deadline (cfg_we, cfg_data)
// Register, unregister and stop-all: the result passes out_r and then the wrapper's hold.
// Process: a start step, then scans of a slot per cycle plus a decision step; k fired
// timers need k+1 scans, or MaxResults scans at the cap, and each fired beat but the last
// at the cap leaves one scan after its slot was found.
// Reset clears slot valid bits, next_id, the queue and the reload setting, not slot contents.
// A stalled result holds the back end; the front queue takes two commands, then drops ready.
module repeating_timer_bank (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_data,
  rtb_cmd_if.sink cmd,
  rtb_res_if.source res
);
  logic reload_from_deadline;
  logic q_valid;
  logic q_pop;
  rtb_pkg::cmd_t q_data;

  always_ff @(posedge clk) begin
    if (rst) reload_from_deadline <= 1'b0;
    else if (cfg_we) reload_from_deadline <= cfg_data;
  end

  rtb_front u_front (.clk, .rst, .cmd, .q_valid, .q_pop, .q_data);
  rtb_back_wrap u_back (.clk, .rst, .reload_from_deadline, .q_valid, .q_pop,
                        .q_data, .res);

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.ready && res.kind != rtb_pkg::KIND_FIRED |-> res.last)
    else $error("non-fired beat without last");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.ready |=> res.valid && $stable(res.timer_id))
    else $error("result dropped under stall");
endmodule

>>> hdl/rtb_front.sv
// Command front end: a two-entry queue that decouples intake from execution.
module rtb_front (
  input  logic clk,
  input  logic rst,
  rtb_cmd_if.sink cmd,
  output logic q_valid,
  input  logic q_pop,
  output rtb_pkg::cmd_t q_data
);
  rtb_pkg::cmd_t mem [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;
  logic push;

  assign cmd.ready = (count != 2'd2);
  assign push = cmd.valid && cmd.ready;
  assign q_valid = (count != 2'd0);
  assign q_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{mode: cmd.mode, now_us: cmd.now_us,
                       start_after_us: cmd.start_after_us,
                       repeat_us: cmd.repeat_us, target_id: cmd.target_id};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

>>> hdl/rtb_back.sv
// Slot bank and execution sequencer; at most one result beat per step.
module rtb_back (
  input  logic clk,
  input  logic rst,
  input  logic reload_from_deadline,
  input  logic q_valid,
  output logic q_pop,
  input  rtb_pkg::cmd_t q_data,
  rtb_res_if.source res
);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  logic [1:0] state;
  logic [rtb_pkg::NumTimers-1:0] valid_q;
  logic [rtb_pkg::NumTimers-1:0] taken;
  logic [63:0] deadline [rtb_pkg::NumTimers];
  logic [63:0] rep [rtb_pkg::NumTimers];
  logic [31:0] sid [rtb_pkg::NumTimers];
  logic [31:0] next_id;
  logic [rtb_pkg::CntW-1:0] fired;
  logic [63:0] now_q;

  // Scan registers: walk slots one per cycle to find the earliest due one.
  logic [rtb_pkg::SlotW-1:0] scan_idx;
  logic [rtb_pkg::SlotW-1:0] best_idx;
  logic best_found;
  logic [63:0] best_dl;
  logic [31:0] best_id;

  // A fired timer waits until the next scan or the cap flush shows if it is the final beat.
  logic pend_valid;
  logic [31:0] pend_id;
  logic [63:0] pend_dl;

  logic out_valid;
  rtb_pkg::result_t out_r;
  rtb_pkg::result_t beat;

  logic cand;
  logic better;
  logic scan_end;
  logic [rtb_pkg::SlotW-1:0] free_idx;
  logic free_found;
  logic can_load;
  logic start_proc;
  logic go_fire;
  logic go_end;
  logic go_flush;
  logic emit;
  logic cap_hit;

  assign res.valid = out_valid;
  assign res.kind = out_r.kind;
  assign res.timer_id = out_r.timer_id;
  assign res.due_time_us = out_r.due_time_us;
  assign res.last = out_r.last;

  assign cand = valid_q[scan_idx] && !taken[scan_idx] &&
                (deadline[scan_idx] <= now_q);
  assign better = !best_found || (deadline[scan_idx] < best_dl) ||
                  ((deadline[scan_idx] == best_dl) && (sid[scan_idx] < best_id));
  assign scan_end = (scan_idx == rtb_pkg::SlotW'(rtb_pkg::NumTimers - 1));

  always_comb begin
    free_found = 1'b0;
    free_idx = '0;
    for (int i = rtb_pkg::NumTimers - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx = rtb_pkg::SlotW'(i);
      end
    end
  end

  assign can_load = !out_valid || res.ready;
  assign q_pop = (state == ST_IDLE) && q_valid && can_load;
  assign start_proc = q_pop && (q_data.mode == rtb_pkg::MODE_PROCESS);
  assign go_fire = (state == ST_DECIDE) && best_found && (!pend_valid || can_load);
  assign go_end = (state == ST_DECIDE) && !best_found && can_load;
  assign go_flush = (state == ST_FLUSH) && can_load;
  assign emit = (q_pop && !start_proc) || (go_fire && pend_valid) || go_end || go_flush;
  assign cap_hit = (fired == rtb_pkg::CntW'(rtb_pkg::MaxResults - 1));

  always_comb begin
    beat = '{kind: rtb_pkg::KIND_REMOVED, timer_id: '0, due_time_us: '0, last: 1'b1};
    if (state == ST_IDLE) begin
      if (q_data.mode == rtb_pkg::MODE_REGISTER) begin
        if (free_found) begin
          beat.kind = rtb_pkg::KIND_REGISTERED;
          beat.timer_id = next_id + 32'd1;
          beat.due_time_us = q_data.now_us + q_data.start_after_us;
        end else begin
          beat.kind = rtb_pkg::KIND_FULL;
        end
      end
    end else if ((state == ST_DECIDE) && best_found) begin
      beat = '{kind: rtb_pkg::KIND_FIRED, timer_id: pend_id, due_time_us: pend_dl,
               last: 1'b0};
    end else if (pend_valid) begin
      beat = '{kind: rtb_pkg::KIND_FIRED, timer_id: pend_id, due_time_us: pend_dl,
               last: 1'b1};
    end else begin
      beat = '{kind: rtb_pkg::KIND_NOTHING_DUE, timer_id: '0, due_time_us: '0,
               last: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (emit) out_r <= beat;
    if (start_proc) now_q <= q_data.now_us;
    if (go_fire) begin
      pend_id <= best_id;
      pend_dl <= best_dl;
    end
    if ((state == ST_SCAN) && cand && better) begin
      best_idx <= scan_idx;
      best_dl <= deadline[scan_idx];
      best_id <= sid[scan_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && (q_data.mode == rtb_pkg::MODE_REGISTER) && free_found) begin
      sid[free_idx] <= next_id + 32'd1;
      deadline[free_idx] <= q_data.now_us + q_data.start_after_us;
      rep[free_idx] <= q_data.repeat_us;
    end else if (go_fire && (rep[best_idx] != 64'd0)) begin
      deadline[best_idx] <= (reload_from_deadline ? best_dl : now_q) + rep[best_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      valid_q <= '0;
      next_id <= '0;
      out_valid <= 1'b0;
      taken <= '0;
      fired <= '0;
      scan_idx <= '0;
      best_found <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (emit) out_valid <= 1'b1;
      else if (res.ready) out_valid <= 1'b0;

      if (q_pop) begin
        case (q_data.mode)
          rtb_pkg::MODE_REGISTER: begin
            if (free_found) valid_q[free_idx] <= 1'b1;
          end
          rtb_pkg::MODE_UNREGISTER: begin
            for (int i = 0; i < rtb_pkg::NumTimers; i++) begin
              if (valid_q[i] && (sid[i] == q_data.target_id)) valid_q[i] <= 1'b0;
            end
          end
          rtb_pkg::MODE_STOP_ALL: valid_q <= '0;
          default: ;
        endcase
      end else if (go_fire && (rep[best_idx] == 64'd0)) begin
        valid_q[best_idx] <= 1'b0;
      end

      if (q_pop && (q_data.mode == rtb_pkg::MODE_REGISTER) && free_found) begin
        next_id <= next_id + 32'd1;
      end

      if (start_proc) begin
        taken <= '0;
        fired <= '0;
      end else if (go_fire) begin
        taken[best_idx] <= 1'b1;
        fired <= fired + rtb_pkg::CntW'(1);
      end

      if (start_proc) pend_valid <= 1'b0;
      else if (go_fire) pend_valid <= 1'b1;
      else if (go_end || go_flush) pend_valid <= 1'b0;

      if (state == ST_SCAN) begin
        scan_idx <= scan_end ? '0 : scan_idx + 1'b1;
      end

      if (state == ST_SCAN) begin
        if (cand && better) best_found <= 1'b1;
      end else if ((state != ST_DECIDE) || go_fire) begin
        best_found <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (start_proc) state <= ST_SCAN;
        end
        ST_SCAN: begin
          if (scan_end) state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (go_fire) state <= cap_hit ? ST_FLUSH : ST_SCAN;
          else if (go_end) state <= ST_IDLE;
        end
        ST_FLUSH: begin
          if (go_flush) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

>>> hdl/rtb_back_wrap.sv
// Back end followed by a one-beat result register toward the output port.
module rtb_back_wrap (
  input  logic clk,
  input  logic rst,
  input  logic reload_from_deadline,
  input  logic q_valid,
  output logic q_pop,
  input  rtb_pkg::cmd_t q_data,
  rtb_res_if.source res
);
  rtb_res_if inner (.clk(clk));
  logic hold_valid;
  rtb_pkg::result_t hold;

  rtb_back u_core (.clk, .rst, .reload_from_deadline, .q_valid, .q_pop,
                   .q_data, .res(inner));

  assign inner.ready = !hold_valid || res.ready;
  assign res.valid = hold_valid;
  assign res.kind = hold.kind;
  assign res.timer_id = hold.timer_id;
  assign res.due_time_us = hold.due_time_us;
  assign res.last = hold.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (inner.ready) begin
      hold_valid <= inner.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (inner.valid && inner.ready) begin
      hold <= '{kind: inner.kind, timer_id: inner.timer_id,
                due_time_us: inner.due_time_us, last: inner.last};
    end
  end
endmodule

>>> bench/repeating_timer_bank_tb.sv
// Self-checking testbench for the repeating timer bank: directed table, then random traffic.
`timescale 1ns / 1ps
module repeating_timer_bank_tb;
  typedef struct {
    logic [1:0] mode;
    logic [63:0] now_us;
    logic [63:0] start_after_us;
    logic [63:0] repeat_us;
    logic [31:0] target_id;
    bit has_exp;
    logic [2:0] exp_kind;
    logic [31:0] exp_id;
    logic [63:0] exp_due;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_data = 1'b0;

  rtb_cmd_if cmd (clk);
  rtb_res_if res (clk);

  repeating_timer_bank u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data), .cmd(cmd), .res(res)
  );

  always #6 clk = ~clk;

  // Predictor state: a shadow copy of the timer table.
  bit tbl_valid [rtb_pkg::NumTimers];
  logic [63:0] tbl_deadline [rtb_pkg::NumTimers];
  logic [63:0] tbl_repeat [rtb_pkg::NumTimers];
  logic [31:0] tbl_id [rtb_pkg::NumTimers];
  logic [31:0] id_counter;
  bit reload_old;

  rtb_pkg::result_t pending_results [$];
  int errors = 0;
  int results_seen = 0;
  int fired_seen = 0;
  int full_seen = 0;
  int beats_sent = 0;
  bit long_stall = 1'b0;

  function automatic rtb_pkg::result_t mk_res(logic [2:0] k, logic [31:0] id,
                                              logic [63:0] due, logic lst);
    rtb_pkg::result_t r;
    r.kind = k;
    r.timer_id = id;
    r.due_time_us = due;
    r.last = lst;
    return r;
  endfunction

  task automatic predict_timers(input logic [1:0] mode, input logic [63:0] now,
                                input logic [63:0] after, input logic [63:0] rpt,
                                input logic [31:0] target);
    int free_slot;
    int best;
    int n;
    bit taken [rtb_pkg::NumTimers];
    rtb_pkg::result_t batch [$];
    free_slot = -1;
    n = 0;
    case (mode)
      rtb_pkg::MODE_REGISTER: begin
        for (int i = rtb_pkg::NumTimers - 1; i >= 0; i--) if (!tbl_valid[i]) free_slot = i;
        if (free_slot < 0) begin
          batch.push_back(mk_res(rtb_pkg::KIND_FULL, '0, '0, 1'b0));
        end else begin
          id_counter = id_counter + 32'd1;
          tbl_valid[free_slot] = 1'b1;
          tbl_id[free_slot] = id_counter;
          tbl_deadline[free_slot] = now + after;
          tbl_repeat[free_slot] = rpt;
          batch.push_back(mk_res(rtb_pkg::KIND_REGISTERED, id_counter, now + after, 1'b0));
        end
      end
      rtb_pkg::MODE_UNREGISTER: begin
        for (int i = 0; i < rtb_pkg::NumTimers; i++)
          if (tbl_valid[i] && tbl_id[i] == target) tbl_valid[i] = 1'b0;
        batch.push_back(mk_res(rtb_pkg::KIND_REMOVED, '0, '0, 1'b0));
      end
      rtb_pkg::MODE_PROCESS: begin
        foreach (taken[i]) taken[i] = 1'b0;
        while (n < rtb_pkg::MaxResults) begin
          best = -1;
          for (int i = 0; i < rtb_pkg::NumTimers; i++) begin
            if (tbl_valid[i] && !taken[i] && tbl_deadline[i] <= now) begin
              if (best < 0 || tbl_deadline[i] < tbl_deadline[best] ||
                  (tbl_deadline[i] == tbl_deadline[best] && tbl_id[i] < tbl_id[best]))
                best = i;
            end
          end
          if (best < 0) break;
          taken[best] = 1'b1;
          batch.push_back(mk_res(rtb_pkg::KIND_FIRED, tbl_id[best], tbl_deadline[best],
                                 1'b0));
          n++;
          if (tbl_repeat[best] != 0)
            tbl_deadline[best] = (reload_old ? tbl_deadline[best] : now) + tbl_repeat[best];
          else
            tbl_valid[best] = 1'b0;
        end
        if (n == 0) batch.push_back(mk_res(rtb_pkg::KIND_NOTHING_DUE, '0, '0, 1'b0));
      end
      default: begin
        foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
        batch.push_back(mk_res(rtb_pkg::KIND_REMOVED, '0, '0, 1'b0));
      end
    endcase
    batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) pending_results.push_back(batch[i]);
  endtask

  // Sends one command beat and queues its predicted results at acceptance.
  // Valid stays high after acceptance; a later gap, write_reload or the caller drops it.
  task automatic send_cmd(input logic [1:0] mode, input logic [63:0] now,
                          input logic [63:0] after, input logic [63:0] rpt,
                          input logic [31:0] target);
    int gap;
    gap = $urandom_range(0, 10);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      cmd.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd.valid <= 1'b1;
    cmd.mode <= mode;
    cmd.now_us <= now;
    cmd.start_after_us <= after;
    cmd.repeat_us <= rpt;
    cmd.target_id <= target;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    predict_timers(mode, now, after, rpt, target);
    beats_sent++;
  endtask

  task automatic write_reload(input bit value);
    cmd.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    // A process command scans all slots again for each fired slot.
    repeat (rtb_pkg::NumTimers * 20) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    reload_old = value;
    cfg_we <= 1'b0;
  endtask

  // Result checker and receiver stalls.
  initial begin
    int stall;
    rtb_pkg::result_t got;
    rtb_pkg::result_t want;
    res.ready = 1'b0;
    @(negedge rst);
    forever begin
      if (long_stall) begin
        res.ready <= 1'b0;
        repeat (400) @(posedge clk);
        long_stall = 1'b0;
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        res.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res.ready <= 1'b1;
      @(posedge clk);
      while (!res.valid) @(posedge clk);
      got = mk_res(res.kind, res.timer_id, res.due_time_us, res.last);
      results_seen++;
      if (got.kind == rtb_pkg::KIND_FIRED) fired_seen++;
      if (got.kind == rtb_pkg::KIND_FULL) full_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat: kind %0d id %0d due %0h",
                                   got.kind, got.timer_id, got.due_time_us);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp kind %0d id %0d due %0h last %0b, got %0d %0d %0h %0b",
                     want.kind, want.timer_id, want.due_time_us, want.last,
                     got.kind, got.timer_id, got.due_time_us, got.last);
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

  // Directed table; expectations filled only for the obvious rows.
  row_t directed [] = '{
    '{rtb_pkg::MODE_PROCESS, 64'd100, 0, 0, 0, 1, rtb_pkg::KIND_NOTHING_DUE, 0, 0},
    '{rtb_pkg::MODE_UNREGISTER, 0, 0, 0, 32'hFFFF_FFFF, 1, rtb_pkg::KIND_REMOVED, 0, 0},
    '{rtb_pkg::MODE_REGISTER, 64'd0, 64'd0, 64'd0, 0, 1, rtb_pkg::KIND_REGISTERED, 1, 0},
    '{rtb_pkg::MODE_REGISTER, 64'hFFFF_FFFF_FFFF_FFFF, 64'd2, 64'd5, 0, 0, 0, 0, 0},
    '{rtb_pkg::MODE_REGISTER, 64'd10, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
      0, 0, 0, 0, 0},
    '{rtb_pkg::MODE_REGISTER, 64'd0, 64'd1, 64'd3, 0, 0, 0, 0, 0},
    '{rtb_pkg::MODE_PROCESS, 64'd1, 0, 0, 0, 0, 0, 0, 0},
    '{rtb_pkg::MODE_PROCESS, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 0, 0, 0, 0},
    '{rtb_pkg::MODE_UNREGISTER, 0, 0, 0, 32'd4, 1, rtb_pkg::KIND_REMOVED, 0, 0},
    '{rtb_pkg::MODE_STOP_ALL, 0, 0, 0, 0, 1, rtb_pkg::KIND_REMOVED, 0, 0},
    '{rtb_pkg::MODE_PROCESS, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 1,
      rtb_pkg::KIND_NOTHING_DUE, 0, 0}
  };

  initial begin
    logic [63:0] now;
    logic [63:0] after;
    logic [63:0] rpt;
    logic [31:0] target;
    int pick;
    cmd.valid = 1'b0;
    cmd.mode = rtb_pkg::MODE_PROCESS;
    cmd.now_us = '0;
    cmd.start_after_us = '0;
    cmd.repeat_us = '0;
    cmd.target_id = '0;
    foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
    id_counter = '0;
    reload_old = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    write_reload(1'b0);

    foreach (directed[r]) begin
      send_cmd(directed[r].mode, directed[r].now_us, directed[r].start_after_us,
               directed[r].repeat_us, directed[r].target_id);
      if (directed[r].has_exp) begin
        if (pending_results[$] !== mk_res(directed[r].exp_kind, directed[r].exp_id,
                                         directed[r].exp_due, 1'b1)) begin
          errors++;
          if (errors <= 10) $display("directed row %0d: prediction disagrees with table", r);
        end
      end
    end

    // Fill the table, hit full, then fire sixteen due timers at once.
    for (int i = 0; i < rtb_pkg::NumTimers + 2; i++)
      send_cmd(rtb_pkg::MODE_REGISTER, 64'd50, 64'(i % 3), (i % 2) ? 64'd7 : 64'd0, '0);
    send_cmd(rtb_pkg::MODE_PROCESS, 64'd1000, '0, '0, '0);
    send_cmd(rtb_pkg::MODE_PROCESS, 64'd1000, '0, '0, '0);
    write_reload(1'b1);
    send_cmd(rtb_pkg::MODE_PROCESS, 64'd1000, '0, '0, '0);
    send_cmd(rtb_pkg::MODE_STOP_ALL, '0, '0, '0, '0);

    // Random part: mixed registrations, unregistrations, process calls and rare stop-alls.
    now = 64'd0;
    for (int k = 0; k < 190; k++) begin
      if (k == 60) long_stall = 1'b1;
      if (k == 110) write_reload(1'b0);
      if (k == 170) write_reload(1'b1);
      now = now + 64'($urandom_range(0, 40));
      if ($urandom_range(0, 15) == 0) now = {$urandom, $urandom};
      after = 64'($urandom_range(0, 60));
      rpt = ($urandom_range(0, 2) == 0) ? 64'd0 : 64'($urandom_range(1, 50));
      if ($urandom_range(0, 9) == 0) after = {$urandom, $urandom};
      if ($urandom_range(0, 9) == 0) rpt = {$urandom, $urandom};
      target = ($urandom_range(0, 3) == 0) ? 32'($urandom) :
               id_counter - 32'($urandom_range(0, 8));
      pick = $urandom_range(0, 99);
      if (pick < 45) send_cmd(rtb_pkg::MODE_REGISTER, now, after, rpt, target);
      else if (pick < 60) send_cmd(rtb_pkg::MODE_UNREGISTER, now, after, rpt, target);
      else if (pick < 96) send_cmd(rtb_pkg::MODE_PROCESS, now, after, rpt, target);
      else send_cmd(rtb_pkg::MODE_STOP_ALL, now, after, rpt, target);
    end

    cmd.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (rtb_pkg::NumTimers * 20) @(posedge clk);
    $display("Sent %0d command beats; checked %0d result beats (%0d fired, %0d full).",
             beats_sent, results_seen, fired_seen, full_seen);
    $display("Both reload settings, a long receiver stall and id/time extremes were run.");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

>>> files.f
hdl/rtb_pkg.sv
hdl/rtb_if.sv
hdl/rtb_front.sv
hdl/rtb_back.sv
hdl/repeating_timer_bank.sv
hdl/rtb_back_wrap.sv
bench/repeating_timer_bank_tb.sv
